FILE: src/dtpu_pkg.sv
`default_nettype none
package dtpu_pkg;

  localparam int MaxColumns = 4096;
  localparam int MaxRows    = 4096;
  localparam int IdxW       = $clog2(MaxColumns);
  localparam int RowW       = $clog2(MaxRows);
  localparam int CntW       = 25;
  localparam int CoordW     = 40;
  localparam int DepthW     = 16;
  localparam int FocalW     = 24;
  localparam int CenterW    = 21;
  localparam int StrideW    = 8;
  localparam int CfgW       = 24;
  localparam int CfgIdxW    = 3;
  // Numerator magnitude: |256*idx - c| < 2^21, times z (16 bits), times 256.
  localparam int MagW       = 22;
  localparam int NumW       = MagW + DepthW + 8;
  localparam int QueueDepth = 4;
  localparam int QueueAw    = $clog2(QueueDepth);

  localparam logic [CfgIdxW-1:0] RegStride  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegFocalX  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegFocalY  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCenterX = 3'd3;
  localparam logic [CfgIdxW-1:0] RegCenterY = 3'd4;
  localparam logic [CfgIdxW-1:0] RegDepthMin = 3'd5;
  localparam logic [CfgIdxW-1:0] RegDepthMax = 3'd6;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusNoDepth = 2'd1;
  localparam logic [1:0] StatusCfgBad  = 2'd2;

  typedef struct packed {
    logic [DepthW-1:0] depth_sample;
    logic              row_end;
    logic              frame_end;
  } pixel_t;

  typedef struct packed {
    logic [CoordW-1:0] point_x;
    logic [CoordW-1:0] point_y;
    logic [DepthW-1:0] point_z;
    logic              item_kind;
    logic [1:0]        frame_status;
    logic [CntW-1:0]   kept_count;
    logic [CntW-1:0]   rejected_count;
    logic [CntW-1:0]   sampled_count;
    logic              last_result;
  } result_t;

  // Work handed from the front part to the back part.
  typedef struct packed {
    logic              has_point;
    logic              has_summary;
    logic              x_neg;
    logic [MagW-1:0]   x_mag;
    logic              y_neg;
    logic [MagW-1:0]   y_mag;
    logic [DepthW-1:0] z;
    logic [1:0]        status;
    logic [CntW-1:0]   kept;
    logic [CntW-1:0]   rejected;
    logic [CntW-1:0]   sampled;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIVIDE,
    BK_POINT,
    BK_SUMMARY
  } back_state_t;

endpackage
`default_nettype wire

FILE: src/dtpu_stream_if.sv
`default_nettype none
interface dtpu_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/dtpu_front.sv
`default_nettype none
module dtpu_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire dtpu_pkg::pixel_t              in_data,
  input  wire logic [dtpu_pkg::StrideW-1:0]  sample_stride,
  input  wire logic [dtpu_pkg::FocalW-1:0]   focal_x,
  input  wire logic [dtpu_pkg::FocalW-1:0]   focal_y,
  input  wire logic [dtpu_pkg::CenterW-1:0]  center_x,
  input  wire logic [dtpu_pkg::CenterW-1:0]  center_y,
  input  wire logic [dtpu_pkg::DepthW-1:0]   depth_min,
  input  wire logic [dtpu_pkg::DepthW-1:0]   depth_max,
  output logic                               job_valid,
  input  wire logic                          job_ready,
  output dtpu_pkg::job_t                     job
);
  import dtpu_pkg::*;

  logic [IdxW-1:0]    column_index;
  logic [RowW-1:0]    row_index;
  logic [StrideW-1:0] column_phase;
  logic [StrideW-1:0] row_phase;
  logic [CntW-1:0]    kept_total;
  logic [CntW-1:0]    rejected_total;
  logic [CntW-1:0]    sampled_total;

  logic               cfg_ok;
  logic               sampled;
  logic               in_range;
  logic               keep;
  logic               accept;
  logic [StrideW-1:0] step;
  logic [CntW-1:0]    kept_next;
  logic [CntW-1:0]    rejected_next;
  logic [CntW-1:0]    sampled_next;
  logic signed [MagW-1:0] dx;
  logic signed [MagW-1:0] dy;

  assign cfg_ok = (focal_x != '0) && (focal_y != '0) && (depth_min != '0) &&
                  (depth_max > depth_min);
  assign step     = (sample_stride == '0) ? StrideW'(1) : sample_stride;
  assign sampled  = cfg_ok && (column_phase == '0) && (row_phase == '0);
  assign in_range = (in_data.depth_sample >= depth_min) &&
                    (in_data.depth_sample <= depth_max);
  assign keep     = sampled && in_range;
  assign in_ready = job_ready;
  assign accept   = in_valid && in_ready;

  // Saturating counts including this pixel.
  assign sampled_next  = (sampled && sampled_total != '1) ? sampled_total + 1'b1 : sampled_total;
  assign kept_next     = (keep && kept_total != '1) ? kept_total + 1'b1 : kept_total;
  assign rejected_next = (sampled && !in_range && rejected_total != '1) ?
                         rejected_total + 1'b1 : rejected_total;

  // Signed offsets from the principal point in Q.8 pixels.
  assign dx = $signed({2'b00, column_index, 8'd0}) - $signed({center_x[CenterW-1], center_x});
  assign dy = $signed({2'b00, row_index, 8'd0}) - $signed({center_y[CenterW-1], center_y});

  // Classify the pixel into a job.
  always_comb begin
    job_valid        = in_valid && (keep || in_data.frame_end);
    job.has_point    = keep;
    job.has_summary  = in_data.frame_end;
    job.x_neg        = dx[MagW-1];
    job.x_mag        = dx[MagW-1] ? MagW'(-dx) : MagW'(dx);
    job.y_neg        = dy[MagW-1];
    job.y_mag        = dy[MagW-1] ? MagW'(-dy) : MagW'(dy);
    job.z            = in_data.depth_sample;
    if (!cfg_ok) begin
      job.status   = StatusCfgBad;
      job.kept     = '0;
      job.rejected = '0;
      job.sampled  = '0;
    end else begin
      job.status   = (kept_next == '0) ? StatusNoDepth : StatusOk;
      job.kept     = kept_next;
      job.rejected = rejected_next;
      job.sampled  = sampled_next;
    end
  end

  // Raster counters and frame totals.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_index   <= '0;
      row_index      <= '0;
      column_phase   <= '0;
      row_phase      <= '0;
      kept_total     <= '0;
      rejected_total <= '0;
      sampled_total  <= '0;
    end else if (accept) begin
      if (in_data.frame_end) begin
        column_index   <= '0;
        row_index      <= '0;
        column_phase   <= '0;
        row_phase      <= '0;
        kept_total     <= '0;
        rejected_total <= '0;
        sampled_total  <= '0;
      end else begin
        kept_total     <= kept_next;
        rejected_total <= rejected_next;
        sampled_total  <= sampled_next;
        if (in_data.row_end) begin
          column_index <= '0;
          column_phase <= '0;
          if (row_index != '1) row_index <= row_index + 1'b1;
          row_phase <= ({1'b0, row_phase} + 1'b1 >= {1'b0, step}) ? '0 : row_phase + 1'b1;
        end else begin
          if (column_index != '1) column_index <= column_index + 1'b1;
          column_phase <= ({1'b0, column_phase} + 1'b1 >= {1'b0, step}) ?
                          '0 : column_phase + 1'b1;
        end
      end
    end
  end

  unused_focal_chk: assert property (@(posedge clk) disable iff (rst)
    (job_valid && job.has_point) |-> (focal_x != '0 && focal_y != '0))
    else $error("point issued with zero focal length");
  kept_cap_chk: assert property (@(posedge clk) disable iff (rst)
    kept_total <= sampled_total)
    else $error("kept count exceeds sampled count");
  summary_cfg_chk: assert property (@(posedge clk) disable iff (rst)
    (job_valid && job.status == StatusCfgBad) |-> !job.has_point)
    else $error("point with invalid configuration");

endmodule
`default_nettype wire

FILE: src/dtpu_queue.sv
`default_nettype none
module dtpu_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire dtpu_pkg::job_t push_data,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output dtpu_pkg::job_t      pop_data
);
  import dtpu_pkg::*;

  job_t               slots [QueueDepth];
  logic [QueueAw-1:0] wr_ptr;
  logic [QueueAw-1:0] rd_ptr;
  logic [QueueAw:0]   fill;
  logic               push;
  logic               pop;

  assign push_ready = (fill != QueueAw'(0) + (QueueAw+1)'(QueueDepth));
  assign pop_valid  = (fill != '0);
  assign pop_data   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Slot storage.
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

  fill_cap_chk: assert property (@(posedge clk) disable iff (rst)
    fill <= (QueueAw+1)'(QueueDepth))
    else $error("queue overfilled");
  ptr_gap_chk: assert property (@(posedge clk) disable iff (rst)
    (fill == '0) |-> (wr_ptr == rd_ptr))
    else $error("empty queue with pointer gap");

endmodule
`default_nettype wire

FILE: src/dtpu_back.sv
`default_nettype none
module dtpu_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        job_valid,
  output logic                             job_ready,
  input  wire dtpu_pkg::job_t              job,
  input  wire logic [dtpu_pkg::FocalW-1:0] focal_x,
  input  wire logic [dtpu_pkg::FocalW-1:0] focal_y,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output dtpu_pkg::result_t                out_data
);
  import dtpu_pkg::*;

  localparam int StepW = $clog2(NumW + 1);

  back_state_t       state;
  back_state_t       state_next;
  job_t              cur;
  logic [NumW-1:0]   num_x;
  logic [NumW-1:0]   num_y;
  logic [NumW-1:0]   quo_x;
  logic [NumW-1:0]   quo_y;
  logic [FocalW:0]   rem_x;
  logic [FocalW:0]   rem_y;
  logic [StepW-1:0]  bit_cnt;
  logic [FocalW+1:0] trial_x;
  logic [FocalW+1:0] trial_y;
  logic [MagW+DepthW-1:0] prod_x;
  logic [MagW+DepthW-1:0] prod_y;
  logic              take;
  logic              out_free;
  logic              emit;
  logic [CoordW-1:0] sat_x;
  logic [CoordW-1:0] sat_y;
  result_t           out_word;

  assign out_free = !out_valid || out_ready;
  assign take     = job_valid && job_ready;
  assign emit     = (state == BK_POINT || state == BK_SUMMARY) && out_free;
  assign prod_x   = MagW'(job.x_mag) * job.z;
  assign prod_y   = MagW'(job.y_mag) * job.z;
  assign trial_x  = {rem_x, num_x[NumW-1]} - {2'b00, focal_x};
  assign trial_y  = {rem_y, num_y[NumW-1]} - {2'b00, focal_y};

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (job_valid) state_next = job.has_point ? BK_DIVIDE : BK_SUMMARY;
      end
      BK_DIVIDE: begin
        if (bit_cnt == StepW'(NumW - 1)) state_next = BK_POINT;
      end
      BK_POINT: begin
        if (out_free) state_next = cur.has_summary ? BK_SUMMARY : BK_IDLE;
      end
      BK_SUMMARY: begin
        if (out_free) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // Outputs of the controller.
  always_comb begin
    job_ready = (state == BK_IDLE);
  end

  // Saturate magnitudes and apply sign.
  always_comb begin
    if (!cur.x_neg)
      sat_x = (quo_x > NumW'(40'h7F_FFFF_FFFF)) ? 40'h7F_FFFF_FFFF : CoordW'(quo_x);
    else
      sat_x = (quo_x > NumW'(40'h80_0000_0000)) ? 40'h80_0000_0000 : CoordW'(-quo_x);
    if (!cur.y_neg)
      sat_y = (quo_y > NumW'(40'h7F_FFFF_FFFF)) ? 40'h7F_FFFF_FFFF : CoordW'(quo_y);
    else
      sat_y = (quo_y > NumW'(40'h80_0000_0000)) ? 40'h80_0000_0000 : CoordW'(-quo_y);
  end

  // Assemble the outgoing word: a point or a frame summary.
  always_comb begin
    out_word = '0;
    if (state == BK_POINT) begin
      out_word.point_x     = sat_x;
      out_word.point_y     = sat_y;
      out_word.point_z     = cur.z;
      out_word.last_result = !cur.has_summary;
    end else begin
      out_word.item_kind      = 1'b1;
      out_word.frame_status   = cur.status;
      out_word.kept_count     = cur.kept;
      out_word.rejected_count = cur.rejected;
      out_word.sampled_count  = cur.sampled;
      out_word.last_result    = 1'b1;
    end
  end

  // Job capture and the restoring divider, one quotient bit a cycle per axis.
  always_ff @(posedge clk) begin
    if (take) begin
      cur     <= job;
      num_x   <= {prod_x, 8'd0};
      num_y   <= {prod_y, 8'd0};
      rem_x   <= '0;
      rem_y   <= '0;
      quo_x   <= '0;
      quo_y   <= '0;
      bit_cnt <= '0;
    end else if (state == BK_DIVIDE) begin
      num_x   <= num_x << 1;
      num_y   <= num_y << 1;
      bit_cnt <= bit_cnt + 1'b1;
      if (!trial_x[FocalW+1]) begin
        rem_x <= trial_x[FocalW:0];
        quo_x <= {quo_x[NumW-2:0], 1'b1};
      end else begin
        rem_x <= {rem_x[FocalW-1:0], num_x[NumW-1]};
        quo_x <= {quo_x[NumW-2:0], 1'b0};
      end
      if (!trial_y[FocalW+1]) begin
        rem_y <= trial_y[FocalW:0];
        quo_y <= {quo_y[NumW-2:0], 1'b1};
      end else begin
        rem_y <= {rem_y[FocalW-1:0], num_y[NumW-1]};
        quo_y <= {quo_y[NumW-2:0], 1'b0};
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) out_data <= out_word;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else state <= state_next;
  end

  rem_x_chk: assert property (@(posedge clk) disable iff (rst)
    (state == BK_DIVIDE) |-> (rem_x < {1'b0, focal_x}))
    else $error("x remainder not below divisor");
  hold_chk: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready && (state == BK_POINT || state == BK_SUMMARY))
    |=> (state == $past(state)))
    else $error("controller advanced under stall");

endmodule
`default_nettype wire

FILE: src/depth_to_point_unprojector_core.sv
`default_nettype none
// A kept pixel's point passes through the queue, the bit-serial divider and output register.
// Throughput: one pixel a cycle while the queue has room; each kept pixel holds the back
// end for capture, bit-serial division and point output; a frame summary for its output.
// Sampled-out and rejected pixels use no back-end time unless they end a frame.
// Reset (rst, synchronous) restores the default registers, counters and empties the queue.
module depth_to_point_unprojector_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  dtpu_stream_if.sink                       pixel_in,
  dtpu_stream_if.source                     result_out,
  input  wire logic                         cfg_we,
  input  wire logic [dtpu_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [dtpu_pkg::CfgW-1:0]    cfg_data
);
  import dtpu_pkg::*;

  logic [StrideW-1:0] sample_stride;
  logic [FocalW-1:0]  focal_x;
  logic [FocalW-1:0]  focal_y;
  logic [CenterW-1:0] center_x;
  logic [CenterW-1:0] center_y;
  logic [DepthW-1:0]  depth_min;
  logic [DepthW-1:0]  depth_max;

  logic fq_valid;
  logic fq_ready;
  job_t fq_job;
  logic qb_valid;
  logic qb_ready;
  job_t qb_job;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_stride <= StrideW'(1);
      focal_x       <= FocalW'(256);
      focal_y       <= FocalW'(256);
      center_x      <= '0;
      center_y      <= '0;
      depth_min     <= DepthW'(100);
      depth_max     <= DepthW'(10000);
    end else if (cfg_we) begin
      case (cfg_index)
        RegStride:   sample_stride <= cfg_data[StrideW-1:0];
        RegFocalX:   focal_x       <= cfg_data[FocalW-1:0];
        RegFocalY:   focal_y       <= cfg_data[FocalW-1:0];
        RegCenterX:  center_x      <= cfg_data[CenterW-1:0];
        RegCenterY:  center_y      <= cfg_data[CenterW-1:0];
        RegDepthMin: depth_min     <= cfg_data[DepthW-1:0];
        RegDepthMax: depth_max     <= cfg_data[DepthW-1:0];
        default: ;
      endcase
    end
  end

  dtpu_front u_front (
    .clk, .rst,
    .in_valid (pixel_in.valid),
    .in_ready (pixel_in.ready),
    .in_data  (pixel_in.data),
    .sample_stride, .focal_x, .focal_y, .center_x, .center_y, .depth_min, .depth_max,
    .job_valid (fq_valid),
    .job_ready (fq_ready),
    .job       (fq_job)
  );

  dtpu_queue u_queue (
    .clk, .rst,
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_job),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_job)
  );

  dtpu_back u_back (
    .clk, .rst,
    .job_valid (qb_valid),
    .job_ready (qb_ready),
    .job       (qb_job),
    .focal_x, .focal_y,
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .out_data  (result_out.data)
  );

endmodule
`default_nettype wire
